// ----- src/cnms_pkg.sv -----
// Shared types and constants for the class-aware NMS engine.
// Used by cnms_iou_unit and class_aware_nms_engine; depends on nothing.
package cnms_pkg;

   typedef struct packed {
      logic signed [15:0] bottom;
      logic signed [15:0] right;
      logic signed [15:0] top;
      logic signed [15:0] left;
   } box_type;

   typedef struct packed {
      logic done;
      logic suppress;
   } iou_res_type;

   localparam logic [15:0] IOU_THR_RESET = 16'd42598;
   localparam logic [10:0] MAX_DET_RESET = 11'd300;

   localparam logic CSR_IOU_THRESHOLD  = 1'b0;
   localparam logic CSR_MAX_DETECTIONS = 1'b1;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

endpackage

// ----- src/class_aware_nms_engine.sv -----
// Class-aware non-maximum suppression engine: candidate store, sort and suppression sequencer.
// Depends on cnms_pkg and cnms_iou_unit.
//
// Push items are taken one per cycle while the engine is idle and store a candidate when
// the store has room; a push marked final starts a run over the n stored candidates, during
// which req_stall stays high. The run first insertion-sorts by falling score, then walks the
// order: a suppressed candidate is skipped and a kept one is recorded, ending the run once
// the detection limit is reached; each later candidate is skipped when already suppressed or
// of another class, and otherwise goes to the overlap unit, whose single multiplier makes
// five products in turn for the full test. A pop holds the input while it reads the kept
// slot and then its candidate (not when nothing is left), plus any wait for the result
// register to drain; pushes are taken while a result waits.
module class_aware_nms_engine #(
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [15:0] req_box_left,
   input  logic signed [15:0] req_box_top,
   input  logic signed [15:0] req_box_right,
   input  logic signed [15:0] req_box_bottom,
   input  logic [15:0]        req_score,
   input  logic [3:0]         req_class_id,
   input  logic               req_final_candidate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_left,
   output logic signed [15:0] rsp_out_top,
   output logic signed [15:0] rsp_out_right,
   output logic signed [15:0] rsp_out_bottom,
   output logic [15:0]        rsp_out_score,
   output logic [3:0]         rsp_out_class,
   output logic               rsp_out_valid,
   output logic               rsp_out_last,
   output logic               rsp_out_overflow,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);
   import cnms_pkg::*;

   localparam int IW = $clog2(MAX_CANDIDATES);
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int KW = (CW > 11) ? CW : 11;
   localparam int OW = 16 + IW;
   localparam logic [CW-1:0] NCAND = CW'(MAX_CANDIDATES);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SORT_SC  = 4'd1;
   localparam logic [3:0] ST_SORT_ST  = 4'd2;
   localparam logic [3:0] ST_SORT_CMP = 4'd3;
   localparam logic [3:0] ST_SORT_PUT = 4'd4;
   localparam logic [3:0] ST_SUP_RD   = 4'd5;
   localparam logic [3:0] ST_SUP_CHK  = 4'd6;
   localparam logic [3:0] ST_SUP_BOXA = 4'd7;
   localparam logic [3:0] ST_Q_RD     = 4'd8;
   localparam logic [3:0] ST_Q_CHK    = 4'd9;
   localparam logic [3:0] ST_Q_BOXB   = 4'd10;
   localparam logic [3:0] ST_Q_IOU    = 4'd11;
   localparam logic [3:0] ST_POP_K    = 4'd12;
   localparam logic [3:0] ST_POP_B    = 4'd13;
   localparam logic [3:0] ST_POP_OUT  = 4'd14;

   // Memories
   box_type     box_mem  [MAX_CANDIDATES];
   logic [19:0] sc_mem   [MAX_CANDIDATES];
   logic [OW-1:0] ord_mem [MAX_CANDIDATES];
   logic        supp_mem [MAX_CANDIDATES];
   logic [IW-1:0] kept_mem [MAX_CANDIDATES];

   box_type       box_rd_ff;
   logic [19:0]   sc_rd_ff;
   logic [OW-1:0] ord_rd_ff;
   logic          supp_rd_ff;
   logic [IW-1:0] kept_rd_ff;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cand_ff, cand_in;
   logic [CW-1:0] kept_cnt_ff, kept_cnt_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   thr_ff;
   logic [10:0]   maxdet_ff;
   logic [CW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] q_ff, q_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [OW-1:0] cur_ff, cur_in;
   box_type       a_box_ff;
   logic [3:0]    a_cls_ff;
   logic          hit_ff, hit_in;

   logic          rsp_valid_ff;
   box_type       rsp_box_ff;
   logic [15:0]   rsp_score_ff;
   logic [3:0]    rsp_class_ff;
   logic          rsp_hit_ff, rsp_last_ff, rsp_ovf_ff;

   logic          req_take;
   logic          push_wr;
   logic          slot_rd_en, ord_rd_en, kept_rd_en;
   logic [IW-1:0] slot_rd_addr, ord_rd_addr, kept_rd_addr;
   logic          ord_wr_en, supp_wr_en, kept_wr_en, supp_wr_val;
   logic [IW-1:0] ord_wr_addr, supp_wr_addr;
   logic [OW-1:0] ord_wr_data;
   logic          iou_start;
   iou_res_type   iou_res;
   logic          out_load;
   logic [CW-1:0] kept_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign push_wr   = req_take && req_action == ACTION_PUSH && cand_ff < NCAND;
   assign out_load  = (state_ff == ST_POP_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign kept_next = kept_ff + CW'(1);

   cnms_iou_unit u_iou (
      .clock         (clock),
      .reset         (reset),
      .start         (iou_start),
      .box_a         (a_box_ff),
      .box_b         (box_rd_ff),
      .iou_threshold (thr_ff),
      .res           (iou_res)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      kept_cnt_in  = kept_cnt_ff;
      rp_in        = rp_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      kept_in      = kept_ff;
      cur_in       = cur_ff;
      hit_in       = hit_ff;
      slot_rd_en   = 1'b0;
      slot_rd_addr = '0;
      ord_rd_en    = 1'b0;
      ord_rd_addr  = '0;
      kept_rd_en   = 1'b0;
      kept_rd_addr = rp_ff[IW-1:0];
      ord_wr_en    = 1'b0;
      ord_wr_addr  = j_ff;
      ord_wr_data  = cur_ff;
      supp_wr_en   = 1'b0;
      supp_wr_addr = '0;
      supp_wr_val  = 1'b0;
      kept_wr_en   = 1'b0;
      iou_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACTION_PUSH) begin
                  if (cand_ff == '0) ovf_in = 1'b0;
                  if (cand_ff < NCAND) cand_in = cand_ff + CW'(1);
                  else ovf_in = 1'b1;
                  if (req_final_candidate) begin
                     i_in     = '0;
                     state_in = ST_SORT_SC;
                  end
               end else if (rp_ff < kept_cnt_ff) begin
                  hit_in   = 1'b1;
                  state_in = ST_POP_K;
               end else begin
                  hit_in   = 1'b0;
                  state_in = ST_POP_OUT;
               end
            end
         end
         // insertion sort: fetch the next score
         ST_SORT_SC: begin
            if (i_ff == cand_ff) begin
               p_in     = '0;
               kept_in  = '0;
               state_in = ST_SUP_RD;
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = i_ff[IW-1:0];
               state_in     = ST_SORT_ST;
            end
         end
         ST_SORT_ST: begin
            cur_in       = {sc_rd_ff[15:0], i_ff[IW-1:0]};
            j_in         = i_ff[IW-1:0];
            supp_wr_en   = 1'b1;
            supp_wr_addr = i_ff[IW-1:0];
            supp_wr_val  = 1'b0;
            if (i_ff == '0) begin
               state_in = ST_SORT_PUT;
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = i_ff[IW-1:0] - IW'(1);
               state_in    = ST_SORT_CMP;
            end
         end
         // shift lower-score entries up one place
         ST_SORT_CMP: begin
            if (ord_rd_ff[OW-1:IW] < cur_ff[OW-1:IW]) begin
               ord_wr_en   = 1'b1;
               ord_wr_addr = j_ff;
               ord_wr_data = ord_rd_ff;
               j_in        = j_ff - IW'(1);
               if (j_ff == IW'(1)) begin
                  state_in = ST_SORT_PUT;
               end else begin
                  ord_rd_en   = 1'b1;
                  ord_rd_addr = j_ff - IW'(2);
               end
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = j_ff;
            ord_wr_data = cur_ff;
            i_in        = i_ff + CW'(1);
            state_in    = ST_SORT_SC;
         end
         // suppression walk: next candidate in score order
         ST_SUP_RD: begin
            if (p_ff == cand_ff) begin
               kept_cnt_in = kept_ff;
               rp_in       = '0;
               cand_in     = '0;
               state_in    = ST_IDLE;
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = p_ff[IW-1:0];
               state_in    = ST_SUP_CHK;
            end
         end
         ST_SUP_CHK: begin
            if (supp_rd_ff) begin
               p_in     = p_ff + CW'(1);
               state_in = ST_SUP_RD;
            end else begin
               kept_wr_en = 1'b1;
               kept_in    = kept_next;
               if (KW'(kept_next) >= KW'(maxdet_ff)) begin
                  kept_cnt_in = kept_next;
                  rp_in       = '0;
                  cand_in     = '0;
                  state_in    = ST_IDLE;
               end else begin
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = ord_rd_ff[IW-1:0];
                  state_in     = ST_SUP_BOXA;
               end
            end
         end
         ST_SUP_BOXA: begin
            q_in     = p_ff + CW'(1);
            state_in = ST_Q_RD;
         end
         ST_Q_RD: begin
            if (q_ff == cand_ff) begin
               p_in     = p_ff + CW'(1);
               state_in = ST_SUP_RD;
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = q_ff[IW-1:0];
               state_in    = ST_Q_CHK;
            end
         end
         ST_Q_CHK: begin
            if (supp_rd_ff) begin
               q_in     = q_ff + CW'(1);
               state_in = ST_Q_RD;
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = ord_rd_ff[IW-1:0];
               state_in     = ST_Q_BOXB;
            end
         end
         ST_Q_BOXB: begin
            if (sc_rd_ff[19:16] != a_cls_ff) begin
               q_in     = q_ff + CW'(1);
               state_in = ST_Q_RD;
            end else begin
               iou_start = 1'b1;
               state_in  = ST_Q_IOU;
            end
         end
         ST_Q_IOU: begin
            if (iou_res.done) begin
               supp_wr_en   = iou_res.suppress;
               supp_wr_addr = q_ff[IW-1:0];
               supp_wr_val  = 1'b1;
               q_in         = q_ff + CW'(1);
               state_in     = ST_Q_RD;
            end
         end
         // pop: kept slot, then its contents
         ST_POP_K: begin
            kept_rd_en = 1'b1;
            state_in   = ST_POP_B;
         end
         ST_POP_B: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = kept_rd_ff;
            state_in     = ST_POP_OUT;
         end
         ST_POP_OUT: begin
            if (out_load) begin
               if (hit_ff) rp_in = rp_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cand_ff     <= '0;
         kept_cnt_ff <= '0;
         rp_ff       <= '0;
         ovf_ff      <= 1'b0;
         thr_ff      <= IOU_THR_RESET;
         maxdet_ff   <= MAX_DET_RESET;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cand_ff     <= cand_in;
         kept_cnt_ff <= kept_cnt_in;
         rp_ff       <= rp_in;
         ovf_ff      <= ovf_in;
         hit_ff      <= hit_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_IOU_THRESHOLD:  thr_ff    <= csr_wdata;
               CSR_MAX_DETECTIONS: maxdet_ff <= csr_wdata[10:0];
               default: ;
            endcase
         end
      end
   end

   // Loop indices and captured operands
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      kept_ff <= kept_in;
      cur_ff  <= cur_in;
      if (state_ff == ST_SUP_BOXA) begin
         a_box_ff <= box_rd_ff;
         a_cls_ff <= sc_rd_ff[19:16];
      end
   end

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (push_wr) begin
         box_mem[cand_ff[IW-1:0]] <= '{bottom: req_box_bottom, right: req_box_right,
                                       top: req_box_top, left: req_box_left};
         sc_mem[cand_ff[IW-1:0]]  <= {req_class_id, req_score};
      end
      if (slot_rd_en) begin
         box_rd_ff <= box_mem[slot_rd_addr];
         sc_rd_ff  <= sc_mem[slot_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ord_wr_en) ord_mem[ord_wr_addr] <= ord_wr_data;
      if (ord_rd_en) ord_rd_ff <= ord_mem[ord_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (supp_wr_en) supp_mem[supp_wr_addr] <= supp_wr_val;
      if (ord_rd_en) supp_rd_ff <= supp_mem[ord_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (kept_wr_en) kept_mem[kept_ff[IW-1:0]] <= ord_rd_ff[IW-1:0];
      if (kept_rd_en) kept_rd_ff <= kept_mem[kept_rd_addr];
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_box_ff   <= hit_ff ? box_rd_ff : '0;
         rsp_score_ff <= hit_ff ? sc_rd_ff[15:0] : '0;
         rsp_class_ff <= hit_ff ? sc_rd_ff[19:16] : '0;
         rsp_hit_ff   <= hit_ff;
         rsp_last_ff  <= hit_ff && (rp_ff + CW'(1) == kept_cnt_ff);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_left     = rsp_box_ff.left;
   assign rsp_out_top      = rsp_box_ff.top;
   assign rsp_out_right    = rsp_box_ff.right;
   assign rsp_out_bottom   = rsp_box_ff.bottom;
   assign rsp_out_score    = rsp_score_ff;
   assign rsp_out_class    = rsp_class_ff;
   assign rsp_out_valid    = rsp_hit_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_out_overflow = rsp_ovf_ff;

endmodule

// ----- src/cnms_iou_unit.sv -----
// Overlap test of two boxes on one shared 18x18 signed multiplier.
// Depends on cnms_pkg (box_type, iou_res_type).
module cnms_iou_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cnms_pkg::box_type     box_a,
   input  cnms_pkg::box_type     box_b,
   input  logic [15:0]           iou_threshold,
   output cnms_pkg::iou_res_type res
);
   import cnms_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ACC  = 2'd2;

   localparam logic [2:0] STEP_INTER = 3'd0;
   localparam logic [2:0] STEP_AREA_A = 3'd1;
   localparam logic [2:0] STEP_AREA_B = 3'd2;
   localparam logic [2:0] STEP_RHS_LO = 3'd3;
   localparam logic [2:0] STEP_RHS_HI = 3'd4;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic signed [16:0] iw_ff, ih_ff, wa_ff, ha_ff, wb_ff, hb_ff;
   logic [15:0]        thr_ff;
   logic signed [35:0] prod_ff;
   logic [33:0]        inter_ff, area_ff, uni_ff, rhs_lo_ff;
   iou_res_type        res_ff, res_in;

   logic signed [17:0] op_a, op_b;
   logic signed [15:0] min_r, max_l, min_b, max_t;
   logic [34:0]        uni_sum;
   logic [50:0]        rhs_full;
   logic [50:0]        lhs_full;

   // Intersection edges
   assign min_r = (box_a.right  < box_b.right)  ? box_a.right  : box_b.right;
   assign max_l = (box_a.left   > box_b.left)   ? box_a.left   : box_b.left;
   assign min_b = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
   assign max_t = (box_a.top    > box_b.top)    ? box_a.top    : box_b.top;

   // Select multiplier operands for the current step
   always_comb begin
      case (step_ff)
         STEP_INTER: begin
            op_a = {iw_ff[16], iw_ff};
            op_b = {ih_ff[16], ih_ff};
         end
         STEP_AREA_A: begin
            op_a = {wa_ff[16], wa_ff};
            op_b = {ha_ff[16], ha_ff};
         end
         STEP_AREA_B: begin
            op_a = {wb_ff[16], wb_ff};
            op_b = {hb_ff[16], hb_ff};
         end
         STEP_RHS_LO: begin
            op_a = {2'b00, thr_ff};
            op_b = {1'b0, uni_ff[16:0]};
         end
         STEP_RHS_HI: begin
            op_a = {2'b00, thr_ff};
            op_b = {1'b0, uni_ff[33:17]};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign uni_sum  = 35'(area_ff) + 35'(prod_ff[33:0]) - 35'(inter_ff);
   assign rhs_full = 51'(rhs_lo_ff) + {prod_ff[33:0], 17'b0};
   assign lhs_full = {1'b0, inter_ff[33:0], 16'b0};

   // Step sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      res_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
               step_in  = STEP_INTER;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (step_ff == STEP_INTER && (iw_ff <= 0 || ih_ff <= 0)) begin
               state_in = ST_IDLE;
               res_in   = '{done: 1'b1, suppress: 1'b0};
            end else if (step_ff == STEP_RHS_HI) begin
               state_in = ST_IDLE;
               res_in   = '{done: 1'b1, suppress: (lhs_full > rhs_full)};
            end else begin
               state_in = ST_MUL;
               step_in  = step_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_INTER;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         res_ff   <= res_in;
      end
   end

   // Operand capture, product register and accumulators
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         iw_ff  <= 17'(min_r) - 17'(max_l);
         ih_ff  <= 17'(min_b) - 17'(max_t);
         wa_ff  <= 17'(box_a.right) - 17'(box_a.left);
         ha_ff  <= 17'(box_a.bottom) - 17'(box_a.top);
         wb_ff  <= 17'(box_b.right) - 17'(box_b.left);
         hb_ff  <= 17'(box_b.bottom) - 17'(box_b.top);
         thr_ff <= iou_threshold;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= op_a * op_b;
      end
      if (state_ff == ST_ACC) begin
         case (step_ff)
            STEP_INTER:  inter_ff  <= prod_ff[33:0];
            STEP_AREA_A: area_ff   <= prod_ff[33:0];
            STEP_AREA_B: uni_ff    <= uni_sum[33:0];
            STEP_RHS_LO: rhs_lo_ff <= prod_ff[33:0];
            default: ;
         endcase
      end
   end

   assign res = res_ff;

`ifndef SYNTH
   a_hit_needs_done: assert property (@(posedge clock) disable iff (reset)
      res_ff.suppress |-> res_ff.done)
      else $error("suppress reported without done");
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("start while busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> step_ff <= STEP_RHS_HI)
      else $error("step out of range");
   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      res_ff.done |-> state_ff == ST_IDLE)
      else $error("done while still busy");
`endif

endmodule

// ----- bench/cnms_checker.sv -----
// Scoreboard for the class-aware NMS engine: tracks the candidate store, runs
// the sort and suppression pass on each final push, and checks every pop result.
// Depends on cnms_pkg.
module cnms_checker #(
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_action,
   input  logic signed [15:0] req_box_left,
   input  logic signed [15:0] req_box_top,
   input  logic signed [15:0] req_box_right,
   input  logic signed [15:0] req_box_bottom,
   input  logic [15:0]        req_score,
   input  logic [3:0]         req_class_id,
   input  logic               req_final_candidate,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_out_left,
   input  logic signed [15:0] rsp_out_top,
   input  logic signed [15:0] rsp_out_right,
   input  logic signed [15:0] rsp_out_bottom,
   input  logic [15:0]        rsp_out_score,
   input  logic [3:0]         rsp_out_class,
   input  logic               rsp_out_valid,
   input  logic               rsp_out_last,
   input  logic               rsp_out_overflow,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   import cnms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      box_type     box;
      logic [15:0] score;
      logic [3:0]  cls;
      logic        valid;
      logic        last;
      logic        overflow;
   } detection_type;

   box_type       cand_box[MAX_CANDIDATES];
   logic [15:0]   cand_score[MAX_CANDIDATES];
   logic [3:0]    cand_class[MAX_CANDIDATES];
   int            rank[MAX_CANDIDATES];
   bit            dropped[MAX_CANDIDATES];
   int            kept_slot[MAX_CANDIDATES];
   int            cand_count, kept_total, read_idx;
   bit            overflow;
   logic [15:0]   iou_thr;
   logic [10:0]   det_limit;
   detection_type pending_detections[$];

   assign pending = pending_detections.size();

   function automatic bit boxes_overlap(int a, int b);
      longint iw, ih, inter, area_a, area_b;
      iw = (cand_box[a].right < cand_box[b].right ? cand_box[a].right : cand_box[b].right)
         - (cand_box[a].left > cand_box[b].left ? cand_box[a].left : cand_box[b].left);
      ih = (cand_box[a].bottom < cand_box[b].bottom ? cand_box[a].bottom : cand_box[b].bottom)
         - (cand_box[a].top > cand_box[b].top ? cand_box[a].top : cand_box[b].top);
      if (iw <= 0 || ih <= 0) return 1'b0;
      inter = iw * ih;
      area_a = (longint'(cand_box[a].right) - cand_box[a].left)
             * (longint'(cand_box[a].bottom) - cand_box[a].top);
      area_b = (longint'(cand_box[b].right) - cand_box[b].left)
             * (longint'(cand_box[b].bottom) - cand_box[b].top);
      return inter * 65536 > longint'(iou_thr) * (area_a + area_b - inter);
   endfunction

   // Stable sort by falling score, then greedy keep-and-suppress per class.
   function automatic void run_suppression();
      int j, s, kept, a;
      for (int i = 0; i < cand_count; i++) begin
         s = cand_score[i];
         j = i;
         while (j > 0 && cand_score[rank[j-1]] < s) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = i;
      end
      for (int i = 0; i < MAX_CANDIDATES; i++) dropped[i] = 1'b0;
      kept = 0;
      for (int p = 0; p < cand_count; p++) begin
         if (dropped[p]) continue;
         a = rank[p];
         kept_slot[kept] = a;
         kept++;
         if (kept >= int'(det_limit)) break;
         for (int q = p + 1; q < cand_count; q++)
            if (!dropped[q] && cand_class[a] == cand_class[rank[q]] && boxes_overlap(a, rank[q]))
               dropped[q] = 1'b1;
      end
      kept_total = kept;
      read_idx = 0;
      cand_count = 0;
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      detection_type d, w;
      if (reset) begin
         cand_count = 0;
         kept_total = 0;
         read_idx = 0;
         overflow = 1'b0;
         iou_thr = IOU_THR_RESET;
         det_limit = MAX_DET_RESET;
         pending_detections.delete();
         fail_count = 0;
      end else begin
         // Track register writes
         if (csr_write_en) begin
            if (csr_index == CSR_IOU_THRESHOLD) iou_thr = csr_wdata;
            else det_limit = csr_wdata[10:0];
         end
         // Predict accepted items
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_PUSH) begin
               if (cand_count == 0) overflow = 1'b0;
               if (cand_count < MAX_CANDIDATES) begin
                  cand_box[cand_count] = '{req_box_bottom, req_box_right, req_box_top,
                                           req_box_left};
                  cand_score[cand_count] = req_score;
                  cand_class[cand_count] = req_class_id;
                  cand_count++;
               end else begin
                  overflow = 1'b1;
               end
               if (req_final_candidate) run_suppression();
            end else begin
               d = '0;
               if (read_idx < kept_total) begin
                  d.box = cand_box[kept_slot[read_idx]];
                  d.score = cand_score[kept_slot[read_idx]];
                  d.cls = cand_class[kept_slot[read_idx]];
                  d.valid = 1'b1;
                  d.last = (read_idx + 1 == kept_total);
                  read_idx++;
               end
               d.overflow = overflow;
               pending_detections.insert(pending_detections.size(), d);
            end
         end
         // Compare accepted results against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_detections.size() == 0) begin
               report("unexpected result", 16'd0, 16'd0);
            end else begin
               w = pending_detections.pop_front();
               if (rsp_out_left !== w.box.left) report("left", rsp_out_left, w.box.left);
               if (rsp_out_top !== w.box.top) report("top", rsp_out_top, w.box.top);
               if (rsp_out_right !== w.box.right) report("right", rsp_out_right, w.box.right);
               if (rsp_out_bottom !== w.box.bottom)
                  report("bottom", rsp_out_bottom, w.box.bottom);
               if (rsp_out_score !== w.score) report("score", rsp_out_score, w.score);
               if (rsp_out_class !== w.cls) report("class", rsp_out_class, w.cls);
               if (rsp_out_valid !== w.valid) report("valid", rsp_out_valid, w.valid);
               if (rsp_out_last !== w.last) report("last", rsp_out_last, w.last);
               if (rsp_out_overflow !== w.overflow)
                  report("overflow", rsp_out_overflow, w.overflow);
            end
         end
      end
   end

endmodule

// ----- bench/testbench.sv -----
// Top of the NMS engine bench: clock, reset, stimulus phases, watchdog and verdict.
// Depends on cnms_pkg, class_aware_nms_engine and cnms_checker.
module testbench;
   import cnms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 400000;

   logic               clock, reset;
   logic               req_valid, req_stall, req_action, req_final_candidate;
   logic signed [15:0] req_box_left, req_box_top, req_box_right, req_box_bottom;
   logic [15:0]        req_score;
   logic [3:0]         req_class_id;
   logic               rsp_valid, rsp_stall;
   logic signed [15:0] rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom;
   logic [15:0]        rsp_out_score;
   logic [3:0]         rsp_out_class;
   logic               rsp_out_valid, rsp_out_last, rsp_out_overflow;
   logic               csr_write_en, csr_index;
   logic [15:0]        csr_wdata;
   int                 fail_count, pending, items_sent, idle_pct, stall_pct, quiet_cycles;

   class_aware_nms_engine DUT (.*);
   cnms_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Randomly stall the result channel
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(logic act, box_type b, logic [15:0] sc, logic [3:0] cls, logic fin);
      bit taken;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_box_left <= b.left;
      req_box_top <= b.top;
      req_box_right <= b.right;
      req_box_bottom <= b.bottom;
      req_score <= sc;
      req_class_id <= cls;
      req_final_candidate <= fin;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic push_box(box_type b, logic [15:0] sc, logic [3:0] cls, logic fin);
      send(ACTION_PUSH, b, sc, cls, fin);
   endtask

   // Pop with random bits on the ignored fields
   task automatic pop_item();
      send(ACTION_POP, box_type'({$urandom, $urandom}), 16'($urandom), 4'($urandom),
           1'($urandom));
   endtask

   // Pop once so any run is over, then hold until every result has come
   task automatic drain();
      pop_item();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic box_type near_box(int cx, int cy);
      int l, t;
      l = cx + $urandom_range(80) - 40;
      t = cy + $urandom_range(80) - 40;
      return '{16'(t + $urandom_range(200, 1)), 16'(l + $urandom_range(200, 1)), 16'(t),
               16'(l)};
   endfunction

   // Mostly well-formed sets of clustered boxes, some noise, pops in between
   task automatic random_traffic(int budget);
      int n, cx, cy, ncls, stop;
      stop = items_sent + budget;
      while (items_sent < stop) begin
         if ($urandom_range(99) < 12) begin
            send(1'($urandom), box_type'({$urandom, $urandom}), 16'($urandom),
                 4'($urandom), ($urandom_range(3) == 0));
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(16, 1);
            ncls = ($urandom_range(3) == 0) ? 15 : $urandom_range(2);
            cx = $urandom_range(4000) - 2000;
            cy = $urandom_range(4000) - 2000;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(19) == 0) pop_item();
               push_box(near_box(cx, cy), ($urandom_range(3) == 0) ? 16'd30000 : 16'($urandom),
                        4'($urandom_range(ncls)), (i == n - 1));
            end
            repeat ($urandom_range(n + 2)) pop_item();
         end
      end
   endtask

   initial begin
      int idle_set[4], stall_set[4];
      box_type unit;
      idle_set = '{0, 72, 0, 34};
      stall_set = '{0, 0, 72, 34};
      idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      req_valid = 1'b0;
      req_action = ACTION_PUSH;
      req_box_left = '0;
      req_box_top = '0;
      req_box_right = '0;
      req_box_bottom = '0;
      req_score = '0;
      req_class_id = '0;
      req_final_candidate = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_IOU_THRESHOLD;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, ties, class separation, touching and extreme boxes
      unit = '{16'sd160, 16'sd160, 16'sd0, 16'sd0};
      pop_item();
      push_box(unit, 16'd1000, 4'd1, 1'b0);
      push_box(unit, 16'd1000, 4'd1, 1'b0);
      push_box(unit, 16'd1000, 4'd2, 1'b0);
      push_box('{16'sd160, 16'sd320, 16'sd0, 16'sd160}, 16'd2000, 4'd1, 1'b0);
      push_box('{16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000}, 16'hffff, 4'd15, 1'b0);
      push_box('{-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff}, 16'd0, 4'd0, 1'b1);
      repeat (7) pop_item();
      drain();

      // Threshold zero: any overlap suppresses
      csr_write(CSR_IOU_THRESHOLD, 16'd0);
      push_box(unit, 16'd500, 4'd3, 1'b0);
      push_box('{16'sd300, 16'sd300, 16'sd159, 16'sd159}, 16'd400, 4'd3, 1'b1);
      repeat (2) pop_item();
      drain();

      // Threshold maximum: only identical boxes suppress
      csr_write(CSR_IOU_THRESHOLD, 16'hffff);
      push_box(unit, 16'd500, 4'd4, 1'b0);
      push_box(unit, 16'd500, 4'd4, 1'b0);
      push_box('{16'sd160, 16'sd161, 16'sd0, 16'sd0}, 16'd400, 4'd4, 1'b1);
      repeat (3) pop_item();
      drain();

      // Store full with a detection limit of one; falling scores keep the sort short
      csr_write(CSR_MAX_DETECTIONS, 16'd1);
      for (int i = 0; i <= 1024; i++)
         push_box(near_box(0, 0), 16'(60000 - i), 4'($urandom), (i == 1024));
      repeat (2) pop_item();
      push_box(unit, 16'd7, 4'd5, 1'b1);
      repeat (2) pop_item();
      drain();

      csr_write(CSR_MAX_DETECTIONS, 16'd1024);
      csr_write(CSR_IOU_THRESHOLD, IOU_THR_RESET);

      // Random phases under different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         random_traffic(100);
         idle_pct = 0;
         stall_pct = 0;
         drain();
         csr_write(CSR_IOU_THRESHOLD, 16'($urandom));
         csr_write(CSR_MAX_DETECTIONS, 16'($urandom_range(1024, 1)));
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- class_aware_nms_engine.f -----
src/cnms_pkg.sv
src/cnms_iou_unit.sv
src/class_aware_nms_engine.sv
bench/cnms_checker.sv
bench/testbench.sv
